// File: rtl/pfrt_pkg.sv
// Shared constants, request/status codes and chain transfer types for the rule table.
package pfrt_pkg;

  localparam int ENTRIES   = 64;
  localparam int PROTOCOLS = 2;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             vld;
    logic             proto;
    logic [15:0]      key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      ip;
    logic [15:0]      tport;
  } tok_t;

  // Slot update broadcast to every cell; the addressed cell takes it.
  typedef struct packed {
    logic             en;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic             proto;
    logic [15:0]      key;
    logic [31:0]      ip;
    logic [15:0]      tport;
  } wr_t;

endpackage

// File: rtl/pfrt_cell.sv
// One rule slot: compares the passing token against its stored key and records free slots.
module pfrt_cell import pfrt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  wr_t              wr_i
);

  logic        valid_q;
  logic        proto_q;
  logic [15:0] key_q;
  logic [31:0] ip_q;
  logic [15:0] tport_q;
  tok_t        tok_d;
  tok_t        tok_q;
  logic        match;
  logic        wr_sel;

  assign match  = tok_i.vld && valid_q && (proto_q == tok_i.proto) && (key_q == tok_i.key);
  assign wr_sel = wr_i.en && (wr_i.idx == idx_i);

  always_comb begin
    tok_d = tok_i;
    if (match && !tok_i.hit) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = idx_i;
      tok_d.ip      = ip_q;
      tok_d.tport   = tport_q;
    end
    // remember the lowest free slot for a possible insert
    if (tok_i.vld && !valid_q && !tok_i.free_ok) begin
      tok_d.free_ok  = 1'b1;
      tok_d.free_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (wr_sel) begin
        valid_q <= !wr_i.clr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel && !wr_i.clr) begin
      proto_q <= wr_i.proto;
      key_q   <= wr_i.key;
      ip_q    <= wr_i.ip;
      tport_q <= wr_i.tport;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/port_forward_rule_table.sv
// Port-forwarding rule table: a request scans a chain of ENTRIES slot cells, one cell per cycle.
// A new request is taken only after the previous one has finished its scan and its done_o cycle.
// busy stays high through the done_o cycle; it drops with the slot update at the edge ending it.
// Reset clears every valid mark and the control state at once; no clearing pass.
// The receiver cannot stall: each result shows for one cycle under done_o.
module port_forward_rule_table import pfrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic        proto_i,
  input  logic [15:0] port_i,
  input  logic [31:0] new_ip_i,
  input  logic [15:0] new_port_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] out_ip_o,
  output logic [15:0] out_port_o
);

  logic        accept;
  logic        busy_q, busy_d;
  logic [1:0]  req_q;
  logic        pok_q;
  logic [31:0] nip_q;
  logic [15:0] nport_q;
  logic        done_q;
  logic [1:0]  status_q, status_d;
  logic [31:0] rip_q, rip_d;
  logic [15:0] rport_q, rport_d;
  wr_t         wr_q, wr_d;
  tok_t        tok [ENTRIES+1];
  tok_t        tok_end;
  logic [ENTRIES-1:0] tok_vld;

  assign accept = start && !busy_q;

  // inject the token straight into the first cell on transfer
  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = accept;
    tok[0].proto    = proto_i;
    tok[0].key      = port_i;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pfrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .wr_i   (wr_q)
    );
    assign tok_vld[g] = tok[g+1].vld;
  end

  assign tok_end = tok[ENTRIES];

  always_comb begin
    busy_d   = busy_q;
    status_d = ST_MISS;
    rip_d    = '0;
    rport_d  = '0;
    wr_d     = '0;
    wr_d.proto = tok_end.proto;
    wr_d.key   = tok_end.key;
    wr_d.ip    = nip_q;
    wr_d.tport = nport_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    // hold busy until the slot update has landed
    if (done_q) begin
      busy_d = 1'b0;
    end
    if (tok_end.vld) begin
      if (pok_q) begin
        case (req_q)
          REQ_LOOKUP: begin
            if (tok_end.hit) begin
              status_d = ST_OK;
              rip_d    = tok_end.ip;
              rport_d  = tok_end.tport;
            end
          end
          REQ_ADD: begin
            if (tok_end.hit) begin
              status_d = ST_OK;
              wr_d.en  = 1'b1;
              wr_d.idx = tok_end.hit_idx;
            end else if (tok_end.free_ok) begin
              status_d = ST_OK;
              wr_d.en  = 1'b1;
              wr_d.idx = tok_end.free_idx;
            end else begin
              status_d = ST_FULL;
            end
          end
          REQ_DELETE: begin
            if (tok_end.hit) begin
              status_d = ST_OK;
              wr_d.en  = 1'b1;
              wr_d.clr = 1'b1;
              wr_d.idx = tok_end.hit_idx;
            end
          end
          default: begin
            status_d = ST_MISS;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      wr_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= tok_end.vld;
      wr_q   <= wr_d;
    end
  end

  // hold request payload for the end of the scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      pok_q   <= (int'(proto_i) < PROTOCOLS);
      nip_q   <= new_ip_i;
      nport_q <= new_port_i;
    end
    status_q <= status_d;
    rip_q    <= rip_d;
    rport_q  <= rport_d;
  end

  assign busy       = busy_q;
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign out_ip_o   = rip_q;
  assign out_port_o = rport_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result shown while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer did not raise busy");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one token in the chain");

  a_wr_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q.en |-> done_o)
    else $error("slot update without a result");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|tok_vld) |-> busy)
    else $error("token in chain while idle");

endmodule

// File: verif/tb_port_forward_rule_table.sv
// Self-checking testbench for the port-forwarding rule table: directed and random requests.
module tb_port_forward_rule_table;
  import pfrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         KEY_POOL    = 96;
  localparam int         CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  req;
    logic        proto;
    logic [15:0] port;
    logic [31:0] ip;
    logic [15:0] nport;
  } fwd_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ip;
    logic [15:0] port;
  } fwd_rsp_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  logic [1:0]  req_type_i = REQ_LOOKUP;
  logic        proto_i    = 1'b0;
  logic [15:0] port_i     = '0;
  logic [31:0] new_ip_i   = '0;
  logic [15:0] new_port_i = '0;
  logic        busy;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] out_ip_o;
  logic [15:0] out_port_o;

  port_forward_rule_table DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .proto_i    (proto_i),
    .port_i     (port_i),
    .new_ip_i   (new_ip_i),
    .new_port_i (new_port_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .out_ip_o   (out_ip_o),
    .out_port_o (out_port_o)
  );

  // Shadow copy of the rule table.
  logic        rule_valid [ENTRIES];
  logic        rule_proto [ENTRIES];
  logic [15:0] rule_key   [ENTRIES];
  logic [31:0] rule_ip    [ENTRIES];
  logic [15:0] rule_tport [ENTRIES];

  fwd_req_t pending_req_q [$];
  fwd_rsp_t expected_rsp_q [$];
  logic        pool_proto [KEY_POOL];
  logic [15:0] pool_port  [KEY_POOL];

  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  bit  taken        = 1'b0;
  int  burst_left   = 1;
  int  gap_left     = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic fwd_rsp_t apply_rule_request(fwd_req_t r);
    fwd_rsp_t rsp;
    int       hit_idx;
    int       free_idx;
    rsp = '{status: ST_MISS, ip: '0, port: '0};
    hit_idx  = -1;
    free_idx = -1;
    if (int'(r.proto) < PROTOCOLS) begin
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (rule_valid[i] && rule_proto[i] == r.proto && rule_key[i] == r.port) hit_idx = i;
        if (!rule_valid[i]) free_idx = i;
      end
      case (r.req)
        REQ_LOOKUP: begin
          if (hit_idx >= 0) begin
            rsp.status = ST_OK;
            rsp.ip     = rule_ip[hit_idx];
            rsp.port   = rule_tport[hit_idx];
          end
        end
        REQ_ADD: begin
          if (hit_idx < 0 && free_idx >= 0) begin
            hit_idx             = free_idx;
            rule_valid[hit_idx] = 1'b1;
            rule_proto[hit_idx] = r.proto;
            rule_key[hit_idx]   = r.port;
          end
          if (hit_idx >= 0) begin
            rule_ip[hit_idx]    = r.ip;
            rule_tport[hit_idx] = r.nport;
            rsp.status          = ST_OK;
          end else begin
            rsp.status = ST_FULL;
          end
        end
        REQ_DELETE: begin
          if (hit_idx >= 0) begin
            rule_valid[hit_idx] = 1'b0;
            rsp.status          = ST_OK;
          end
        end
        default: ;
      endcase
    end
    return rsp;
  endfunction

  task automatic push_req(logic [1:0] req, logic proto, logic [15:0] port,
                          logic [31:0] ip, logic [15:0] nport);
    pending_req_q.push_back('{req: req, proto: proto, port: port, ip: ip, nport: nport});
  endtask

  // Monitor: record each transfer into the shadow table and check every result.
  always @(posedge clk_i) begin
    fwd_rsp_t exp_rsp;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    taken = rst_ni && start && !busy;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d ip=%h port=%h", $time,
                 status_o, out_ip_o, out_port_o);
        mismatch_cnt++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (status_o !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status, status_o);
          mismatch_cnt++;
        end
        if (out_ip_o !== exp_rsp.ip) begin
          $display("%0t: out_ip expected %h actual %h", $time, exp_rsp.ip, out_ip_o);
          mismatch_cnt++;
        end
        if (out_port_o !== exp_rsp.port) begin
          $display("%0t: out_port expected %h actual %h", $time, exp_rsp.port, out_port_o);
          mismatch_cnt++;
        end
      end
    end
    if (taken)
      expected_rsp_q.push_back(apply_rule_request({req_type_i, proto_i, port_i,
                                                   new_ip_i, new_port_i}));
  end

  // Driver: hold a request until its transfer, then send in bursts with random gaps.
  always @(negedge clk_i) begin
    fwd_req_t r;
    if (rst_ni && !(start && !taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_req_q.size() != 0) begin
        r = pending_req_q.pop_front();
        start      <= 1'b1;
        req_type_i <= r.req;
        proto_i    <= r.proto;
        port_i     <= r.port;
        new_ip_i   <= r.ip;
        new_port_i <= r.nport;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    bit          dup;
    int          add_pct;
    int          del_pct;
    int          window;
    int          pick;
    int          roll;
    logic [1:0]  req;
    logic        proto;
    logic [15:0] port;
    logic [15:0] nport;

    for (int i = 0; i < ENTRIES; i++) rule_valid[i] = 1'b0;

    // Directed: empty table, key extremes, rewrite, delete, slot reuse, unused type.
    push_req(REQ_LOOKUP, 1'b0, 16'h0000, 32'hffff_ffff, 16'hffff);
    push_req(REQ_DELETE, 1'b0, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_ADD,    1'b0, 16'h0000, 32'h0000_0000, 16'h0000);
    push_req(REQ_ADD,    1'b1, 16'h0000, 32'hffff_ffff, 16'hffff);
    push_req(REQ_ADD,    1'b0, 16'hffff, 32'hffff_ffff, 16'hffff);
    push_req(REQ_LOOKUP, 1'b0, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_LOOKUP, 1'b1, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_LOOKUP, 1'b0, 16'hffff, 32'h0, 16'h0);
    push_req(REQ_ADD,    1'b0, 16'h0000, 32'h1234_5678, 16'h8001);
    push_req(REQ_LOOKUP, 1'b0, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_UNUSED, 1'b0, 16'h0000, 32'hdead_beef, 16'h0bad);
    push_req(REQ_LOOKUP, 1'b0, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_DELETE, 1'b1, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_LOOKUP, 1'b1, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_DELETE, 1'b1, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_ADD,    1'b1, 16'hffff, 32'ha5a5_a5a5, 16'h5a5a);
    push_req(REQ_LOOKUP, 1'b1, 16'hffff, 32'h0, 16'h0);
    push_req(REQ_LOOKUP, 1'b0, 16'hffff, 32'h0, 16'h0);
    push_req(REQ_UNUSED, 1'b1, 16'h1234, 32'h5555_aaaa, 16'haaaa);
    push_req(REQ_DELETE, 1'b0, 16'h0000, 32'h0, 16'h0);
    push_req(REQ_LOOKUP, 1'b0, 16'h0000, 32'h0, 16'h0);

    // Pool of distinct keys so that random traffic hits, rewrites and deletes.
    for (int i = 0; i < KEY_POOL; i++) begin
      do begin
        pool_proto[i] = 1'($urandom_range(0, 1));
        pool_port[i]  = 16'($urandom_range(0, 65535));
        dup = 1'b0;
        for (int j = 0; j < i; j++)
          if (pool_proto[j] == pool_proto[i] && pool_port[j] == pool_port[i]) dup = 1'b1;
      end while (dup);
    end

    // Fill past capacity so the table-full case shows up.
    for (int i = 0; i < ENTRIES + 4; i++)
      push_req(REQ_ADD, pool_proto[i], pool_port[i], $urandom,
               16'($urandom_range(0, 65535)));
    push_req(REQ_ADD, pool_proto[0], pool_port[0], $urandom, 16'h0000);

    // Random phases: vary the key window and the add/delete balance so the table
    // drains and refills several times.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 2))
        0:       window = 8;
        1:       window = 32;
        default: window = KEY_POOL;
      endcase
      if (ph % 2 == 0) begin
        add_pct = 50;
        del_pct = 15;
      end else begin
        add_pct = 15;
        del_pct = 45;
      end
      for (int n = 0; n < 54; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5)                          req = REQ_UNUSED;
        else if (roll < 5 + add_pct)           req = REQ_ADD;
        else if (roll < 5 + add_pct + del_pct) req = REQ_DELETE;
        else                                   req = REQ_LOOKUP;
        if ($urandom_range(0, 99) < 85) begin
          pick  = $urandom_range(0, window - 1);
          proto = pool_proto[pick];
          port  = pool_port[pick];
        end else begin
          proto = 1'($urandom_range(0, 1));
          port  = 16'($urandom_range(0, 65535));
        end
        nport = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
        push_req(req, proto, port, $urandom, nport);
      end
    end

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_req_q.size() != 0 || start) @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 8) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
